/* sv/qvr_pkg.sv */
package qvr_pkg;

  localparam int NUM_AXES = 3;
  localparam int NUM_PROD = 10;

  typedef enum logic [3:0] {
    P_WW = 4'd0,
    P_XX = 4'd1,
    P_YY = 4'd2,
    P_ZZ = 4'd3,
    P_XY = 4'd4,
    P_WZ = 4'd5,
    P_XZ = 4'd6,
    P_WY = 4'd7,
    P_WX = 4'd8,
    P_YZ = 4'd9
  } prod_e;

endpackage

/* sv/quaternion_vector_rotate.sv */
// Rotates an integer 3-vector by a quaternion in signed Q2.(W-2), applying the frame
// rotation q' * v * q through the transposed rotation matrix built from the quaternion
// squares and doubled cross products. Each sum is formed exactly, rounded half up to an
// integer and saturated to W bits; saturated_o is set when any component was clipped.
// The quaternion is not normalized. The datapath is a six-stage pipeline: quaternion
// products, matrix terms, split partial products against the vector, term assembly, row
// sums with the rounding offset, then rounding and saturation into the output register.
// One transaction is accepted per cycle while the output accepts results; the rate is set
// by the fully pipelined multiplier stages, and a stall at the output holds every stage
// in place while bubbles ahead of it still fill.
module quaternion_vector_rotate #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COMPONENT_WIDTH-1:0] rot_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] rot_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] rot_z_o,
  output logic                              saturated_o
);

  import qvr_pkg::*;

  localparam int W   = COMPONENT_WIDTH;
  localparam int PW  = 2 * W;
  localparam int MW  = 2 * W + 2;
  localparam int HW  = MW - W;
  localparam int PLW = 2 * W + 1;
  localparam int PHW = HW + W;
  localparam int AW  = 3 * W + 4;
  localparam int SH  = 2 * (W - 2);
  localparam int RW  = AW - SH;

  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] RMAX = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] RMIN = -RMAX - RW'(1);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  always_comb begin
    en6 = !v6_q || out_ready_i;
    en5 = !v5_q || en6;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Stage 1: the ten quaternion products.
  logic signed [PW-1:0] prod_d [NUM_PROD];
  logic signed [PW-1:0] prod_q [NUM_PROD];
  logic signed [W-1:0]  vec_in [NUM_AXES];
  logic signed [W-1:0]  vec1_q [NUM_AXES];
  logic signed [W-1:0]  vec2_q [NUM_AXES];

  always_comb begin
    prod_d[P_WW] = PW'(quat_w_i) * PW'(quat_w_i);
    prod_d[P_XX] = PW'(quat_x_i) * PW'(quat_x_i);
    prod_d[P_YY] = PW'(quat_y_i) * PW'(quat_y_i);
    prod_d[P_ZZ] = PW'(quat_z_i) * PW'(quat_z_i);
    prod_d[P_XY] = PW'(quat_x_i) * PW'(quat_y_i);
    prod_d[P_WZ] = PW'(quat_w_i) * PW'(quat_z_i);
    prod_d[P_XZ] = PW'(quat_x_i) * PW'(quat_z_i);
    prod_d[P_WY] = PW'(quat_w_i) * PW'(quat_y_i);
    prod_d[P_WX] = PW'(quat_w_i) * PW'(quat_x_i);
    prod_d[P_YZ] = PW'(quat_y_i) * PW'(quat_z_i);
    vec_in[0]    = vec_x_i;
    vec_in[1]    = vec_y_i;
    vec_in[2]    = vec_z_i;
  end

  // Stage 2: the transposed rotation matrix.
  logic signed [MW-1:0] mat_d [NUM_AXES][NUM_AXES];
  logic signed [MW-1:0] mat_q [NUM_AXES][NUM_AXES];
  logic signed [MW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, wx, yz;

  always_comb begin
    ww = MW'(prod_q[P_WW]);
    xx = MW'(prod_q[P_XX]);
    yy = MW'(prod_q[P_YY]);
    zz = MW'(prod_q[P_ZZ]);
    xy = MW'(prod_q[P_XY]);
    wz = MW'(prod_q[P_WZ]);
    xz = MW'(prod_q[P_XZ]);
    wy = MW'(prod_q[P_WY]);
    wx = MW'(prod_q[P_WX]);
    yz = MW'(prod_q[P_YZ]);
    mat_d[0][0] = ww + xx - yy - zz;
    mat_d[0][1] = (xy + wz) <<< 1;
    mat_d[0][2] = (xz - wy) <<< 1;
    mat_d[1][0] = (xy - wz) <<< 1;
    mat_d[1][1] = ww + yy - xx - zz;
    mat_d[1][2] = (wx + yz) <<< 1;
    mat_d[2][0] = (wy + xz) <<< 1;
    mat_d[2][1] = (yz - wx) <<< 1;
    mat_d[2][2] = ww + zz - xx - yy;
  end

  // Stages 3 and 4: each matrix term times a vector component, split into a low
  // and a high partial product and then reassembled.
  logic signed [PLW-1:0] plo_d  [NUM_AXES][NUM_AXES];
  logic signed [PLW-1:0] plo_q  [NUM_AXES][NUM_AXES];
  logic signed [PHW-1:0] phi_d  [NUM_AXES][NUM_AXES];
  logic signed [PHW-1:0] phi_q  [NUM_AXES][NUM_AXES];
  logic signed [AW-1:0]  term_d [NUM_AXES][NUM_AXES];
  logic signed [AW-1:0]  term_q [NUM_AXES][NUM_AXES];

  // Stage 5: row sums with the rounding offset.
  logic signed [AW-1:0]  row_d [NUM_AXES];
  logic signed [AW-1:0]  row_q [NUM_AXES];

  // Stage 6: rounding shift and saturation.
  logic signed [RW-1:0]  rnd   [NUM_AXES];
  logic [NUM_AXES-1:0]   sat_hi, sat_lo;
  logic signed [W-1:0]   res_d [NUM_AXES];
  logic signed [W-1:0]   res_q [NUM_AXES];
  logic                  sat_d, sat_q;

  for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
    for (genvar c = 0; c < NUM_AXES; c++) begin : g_col
      always_comb begin
        plo_d[r][c]  = PLW'($signed({1'b0, mat_q[r][c][W-1:0]})) * PLW'(vec2_q[c]);
        phi_d[r][c]  = PHW'($signed(mat_q[r][c][MW-1:W])) * PHW'(vec2_q[c]);
        term_d[r][c] = (AW'(phi_q[r][c]) <<< W) + AW'(plo_q[r][c]);
      end
    end

    always_comb begin
      row_d[r]  = term_q[r][0] + term_q[r][1] + term_q[r][2] + HALF;
      rnd[r]    = $signed(row_q[r][AW-1:SH]);
      sat_hi[r] = rnd[r] > RMAX;
      sat_lo[r] = rnd[r] < RMIN;
      if (sat_hi[r]) begin
        res_d[r] = RMAX[W-1:0];
      end else if (sat_lo[r]) begin
        res_d[r] = RMIN[W-1:0];
      end else begin
        res_d[r] = rnd[r][W-1:0];
      end
    end
  end

  assign sat_d = |(sat_hi | sat_lo);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
      vec1_q <= vec_in;
    end
    if (en2) begin
      mat_q  <= mat_d;
      vec2_q <= vec1_q;
    end
    if (en3) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
    end
    if (en4) begin
      term_q <= term_d;
    end
    if (en5) begin
      row_q <= row_d;
    end
    if (en6) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign rot_x_o     = res_q[0];
  assign rot_y_o     = res_q[1];
  assign rot_z_o     = res_q[2];
  assign saturated_o = sat_q;

endmodule
